### rtl/core/rtn_pkg.sv
package rtn_pkg;

    // item kinds
    localparam logic [2:0] K_LOAD_ROUTE = 3'd0;
    localparam logic [2:0] K_LOAD_NB    = 3'd1;
    localparam logic [2:0] K_HOP_FIRST  = 3'd2;
    localparam logic [2:0] K_HOP_LAST   = 3'd3;
    localparam logic [2:0] K_LENGTH     = 3'd4;
    localparam logic [2:0] K_LIMIT      = 3'd5;
    localparam logic [2:0] K_MIN_DIST   = 3'd6;

    localparam logic [7:0]  NO_ZONE     = 8'hFF;
    localparam logic [7:0]  FAR_DIST    = 8'd255;
    localparam logic [23:0] FAIL_LENGTH = 24'd100000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_HOP_CHECK,
        S_SCAN_START,
        S_NB_RD,
        S_NB_DATA,
        S_MUL,
        S_ADDR,
        S_RT_DATA,
        S_CMP,
        S_SCAN_END,
        S_WALK_DEC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        D_ZERO,
        D_FAR,
        D_RAM
    } dsel_t;

    typedef enum logic [2:0] {
        RES_SAME_HOP,
        RES_SAME_MIN,
        RES_HOP,
        RES_MIN,
        RES_WALK,
        RES_FAIL
    } res_t;

    typedef struct packed {
        logic  accept;
        logic  rt_wr;
        logic  nb_wr;
        logic  clr_wr;
        logic  scan_init;
        logic  cand_ld;
        logic  mul_ld;
        logic  d_ld;
        dsel_t d_sel;
        logic  cmp;
        logic  total_add;
        logic  step;
        logic  res_set;
        res_t  res_sel;
        logic  out_ld;
    } cmd_t;

    typedef struct packed {
        logic [2:0] in_kind;
        logic [2:0] kind;
        logic       same;
        logic       cur_oob;
        logic       nb_end;
        logic       nb_is_to;
        logic       addr_oob;
        logic       last_slot;
        logic       hops_max;
        logic       over_limit;
        logic       stuck;
        logic       clr_last;
        logic       out_free;
    } sts_t;

endpackage

### rtl/core/rtn_ram.sv
module rtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/rtn_ctrl.sv
module rtn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rtn_pkg::sts_t st,
    output rtn_pkg::cmd_t cmd
);

    rtn_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtn_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.d_sel  = rtn_pkg::D_ZERO;
        cmd.res_sel = rtn_pkg::RES_HOP;
        unique case (state_reg)
            rtn_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = rtn_pkg::S_IDLE;
                end
            end
            rtn_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (st.in_kind)
                        rtn_pkg::K_LOAD_ROUTE: cmd.rt_wr = 1'b1;
                        rtn_pkg::K_LOAD_NB:    cmd.nb_wr = 1'b1;
                        rtn_pkg::K_HOP_FIRST,
                        rtn_pkg::K_HOP_LAST,
                        rtn_pkg::K_LENGTH,
                        rtn_pkg::K_LIMIT,
                        rtn_pkg::K_MIN_DIST:   state_next = rtn_pkg::S_QUERY;
                        default:               state_next = rtn_pkg::S_IDLE;
                    endcase
                end
            end
            rtn_pkg::S_QUERY:
            begin
                if (st.kind == rtn_pkg::K_LENGTH || st.kind == rtn_pkg::K_LIMIT)
                begin
                    state_next = rtn_pkg::S_HOP_CHECK;
                end
                else if (st.same)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = (st.kind == rtn_pkg::K_MIN_DIST) ?
                                  rtn_pkg::RES_SAME_MIN : rtn_pkg::RES_SAME_HOP;
                    state_next  = rtn_pkg::S_DONE;
                end
                else
                begin
                    state_next = rtn_pkg::S_SCAN_START;
                end
            end
            rtn_pkg::S_HOP_CHECK:
            begin
                if (st.same)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_WALK;
                    state_next  = rtn_pkg::S_DONE;
                end
                else if (st.hops_max)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_FAIL;
                    state_next  = rtn_pkg::S_DONE;
                end
                else
                begin
                    state_next = rtn_pkg::S_SCAN_START;
                end
            end
            rtn_pkg::S_SCAN_START:
            begin
                cmd.scan_init = 1'b1;
                state_next = st.cur_oob ? rtn_pkg::S_SCAN_END : rtn_pkg::S_NB_RD;
            end
            rtn_pkg::S_NB_RD:
            begin
                state_next = rtn_pkg::S_NB_DATA;
            end
            rtn_pkg::S_NB_DATA:
            begin
                if (st.nb_end)
                begin
                    state_next = rtn_pkg::S_SCAN_END;
                end
                else if (st.nb_is_to)
                begin
                    cmd.cand_ld = 1'b1;
                    cmd.d_ld    = 1'b1;
                    cmd.d_sel   = rtn_pkg::D_ZERO;
                    state_next  = rtn_pkg::S_CMP;
                end
                else
                begin
                    cmd.cand_ld = 1'b1;
                    state_next  = rtn_pkg::S_MUL;
                end
            end
            rtn_pkg::S_MUL:
            begin
                cmd.mul_ld = 1'b1;
                state_next = rtn_pkg::S_ADDR;
            end
            rtn_pkg::S_ADDR:
            begin
                if (st.addr_oob)
                begin
                    cmd.d_ld   = 1'b1;
                    cmd.d_sel  = rtn_pkg::D_FAR;
                    state_next = rtn_pkg::S_CMP;
                end
                else
                begin
                    state_next = rtn_pkg::S_RT_DATA;
                end
            end
            rtn_pkg::S_RT_DATA:
            begin
                cmd.d_ld   = 1'b1;
                cmd.d_sel  = rtn_pkg::D_RAM;
                state_next = rtn_pkg::S_CMP;
            end
            rtn_pkg::S_CMP:
            begin
                cmd.cmp = 1'b1;
                state_next = st.last_slot ? rtn_pkg::S_SCAN_END : rtn_pkg::S_NB_RD;
            end
            rtn_pkg::S_SCAN_END:
            begin
                if (st.kind == rtn_pkg::K_HOP_FIRST || st.kind == rtn_pkg::K_HOP_LAST)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_HOP;
                    state_next  = rtn_pkg::S_DONE;
                end
                else if (st.kind == rtn_pkg::K_MIN_DIST)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_MIN;
                    state_next  = rtn_pkg::S_DONE;
                end
                else
                begin
                    cmd.total_add = 1'b1;
                    state_next    = rtn_pkg::S_WALK_DEC;
                end
            end
            rtn_pkg::S_WALK_DEC:
            begin
                if (st.over_limit)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_WALK;
                    state_next  = rtn_pkg::S_DONE;
                end
                else if (st.stuck)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = rtn_pkg::RES_FAIL;
                    state_next  = rtn_pkg::S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = rtn_pkg::S_HOP_CHECK;
                end
            end
            rtn_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = rtn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rtn_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rtn_datapath.sv
module rtn_datapath #(
    parameter int MAX_ZONES  = 128,
    parameter int NEIGHBOURS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic [2:0]    kind,
    input  logic [7:0]    from_zone,
    input  logic [7:0]    to_zone,
    input  logic [23:0]   walk_limit,
    input  logic [12:0]   route_index,
    input  logic [7:0]    route_value,
    input  logic [2:0]    slot,
    input  logic [7:0]    neighbour_zone,
    input  logic [15:0]   link_length,
    input  rtn_pkg::cmd_t cmd,
    output rtn_pkg::sts_t st,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    zone_out,
    output logic [23:0]   length_out,
    output logic [7:0]    route_distance,
    output logic          no_reach
);

    localparam int RT_DEPTH = (MAX_ZONES * (MAX_ZONES - 1)) / 2;
    localparam int RT_AW    = (RT_DEPTH > 1) ? $clog2(RT_DEPTH) : 1;
    localparam int NB_DEPTH = MAX_ZONES * NEIGHBOURS;
    localparam int NB_AW    = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;
    localparam int SW       = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int HW       = $clog2(MAX_ZONES + 1);

    // control registers
    logic [7:0]       zc_reg;
    logic [NB_AW-1:0] clr_cnt_reg;
    logic             out_valid_reg;

    // working registers
    logic [2:0]        kind_reg;
    logic [7:0]        to_reg;
    logic [23:0]       limit_reg;
    logic [7:0]        cur_reg;
    logic [HW-1:0]     hops_reg;
    logic [23:0]       total_reg;
    logic [NB_AW-1:0]  base_reg;
    logic [SW-1:0]     slot_reg;
    logic [7:0]        pick_reg;
    logic [7:0]        best_reg;
    logic [15:0]       link_reg;
    logic [7:0]        cand_zone_reg;
    logic [15:0]       cand_link_reg;
    logic signed [19:0] prod_reg;
    logic [7:0]        hi_reg;
    logic [7:0]        d_reg;
    logic [7:0]        res_zone_reg;
    logic [23:0]       res_len_reg;
    logic [7:0]        res_dist_reg;
    logic              res_fail_reg;
    logic [7:0]        zone_out_reg;
    logic [23:0]       length_out_reg;
    logic [7:0]        route_distance_reg;
    logic              no_reach_reg;

    // result selection
    logic [7:0]        res_zone_next;
    logic [23:0]       res_len_next;
    logic [7:0]        res_dist_next;
    logic              res_fail_next;

    // memories
    logic [RT_AW-1:0] rt_waddr, rt_raddr;
    logic [7:0]       rt_rdata;
    logic             rt_we;
    logic [NB_AW-1:0] nb_waddr, nb_raddr;
    logic [23:0]      nb_wdata, nb_rdata;
    logic             nb_we;

    logic [15:0] load_addr;
    logic [15:0] base_full;
    logic        load_ok;
    logic [7:0]  lo, hi;
    logic signed [10:0] span;
    logic signed [19:0] prod_adj;
    logic signed [19:0] half;
    logic signed [20:0] idx;
    logic        better;

    assign load_addr = 16'(from_zone) * 16'(NEIGHBOURS) + 16'(slot);
    assign load_ok   = ({1'b0, from_zone} < 9'(MAX_ZONES)) && ({1'b0, slot} < 4'(NEIGHBOURS));
    assign base_full = 16'(cur_reg) * 16'(NEIGHBOURS);

    assign rt_we    = cmd.rt_wr && ({3'b000, route_index} < 16'(RT_DEPTH));
    assign rt_waddr = RT_AW'(route_index);

    assign nb_we    = cmd.clr_wr || (cmd.nb_wr && load_ok);
    assign nb_waddr = cmd.clr_wr ? clr_cnt_reg : NB_AW'(load_addr);
    assign nb_wdata = cmd.clr_wr ? {16'd0, rtn_pkg::NO_ZONE} : {link_length, neighbour_zone};
    assign nb_raddr = NB_AW'(base_reg + NB_AW'(slot_reg));

    // triangular address of the candidate/target pair
    assign lo       = (cand_zone_reg < to_reg) ? cand_zone_reg : to_reg;
    assign hi       = (cand_zone_reg < to_reg) ? to_reg : cand_zone_reg;
    assign span     = $signed({2'b00, zc_reg, 1'b0}) - $signed({3'b000, lo}) - 11'sd3;
    assign prod_adj = prod_reg + $signed({19'd0, prod_reg[19]});
    assign half     = prod_adj >>> 1;
    assign idx      = 21'(half) + $signed({13'd0, hi_reg}) - 21'sd1;
    assign rt_raddr = idx[RT_AW-1:0];

    assign better = (d_reg < best_reg) ||
                    ((kind_reg == rtn_pkg::K_HOP_LAST) && (d_reg == best_reg));

    rtn_ram #(.WIDTH(8), .DEPTH(RT_DEPTH)) u_route_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (route_value),
        .raddr (rt_raddr),
        .rdata (rt_rdata)
    );

    rtn_ram #(.WIDTH(24), .DEPTH(NB_DEPTH)) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    always_comb
    begin
        res_zone_next = 8'd0;
        res_len_next  = 24'd0;
        res_dist_next = 8'd0;
        res_fail_next = 1'b0;
        unique case (cmd.res_sel)
            rtn_pkg::RES_SAME_HOP: res_zone_next = to_reg;
            rtn_pkg::RES_SAME_MIN: res_dist_next = to_reg;
            rtn_pkg::RES_HOP:      res_zone_next = pick_reg;
            rtn_pkg::RES_MIN:      res_dist_next = best_reg;
            rtn_pkg::RES_WALK:
            begin
                res_zone_next = cur_reg;
                res_len_next  = total_reg;
            end
            rtn_pkg::RES_FAIL:
            begin
                res_zone_next = cur_reg;
                res_len_next  = (kind_reg == rtn_pkg::K_LENGTH) ?
                                rtn_pkg::FAIL_LENGTH : total_reg;
                res_fail_next = 1'b1;
            end
            default:               res_zone_next = cur_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_reg        <= 8'd128;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                zc_reg <= cfg_wr_data;
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= NB_AW'(clr_cnt_reg + 1'b1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= kind;
            to_reg    <= to_zone;
            limit_reg <= walk_limit;
            cur_reg   <= from_zone;
            hops_reg  <= '0;
            total_reg <= '0;
        end
        if (cmd.scan_init)
        begin
            base_reg <= NB_AW'(base_full);
            slot_reg <= '0;
            pick_reg <= cur_reg;
            best_reg <= rtn_pkg::FAR_DIST;
            link_reg <= '0;
        end
        if (cmd.cand_ld)
        begin
            cand_zone_reg <= nb_rdata[7:0];
            cand_link_reg <= nb_rdata[23:8];
        end
        if (cmd.mul_ld)
        begin
            prod_reg <= 20'($signed({1'b0, lo})) * 20'(span);
            hi_reg   <= hi;
        end
        if (cmd.d_ld)
        begin
            unique case (cmd.d_sel)
                rtn_pkg::D_ZERO: d_reg <= 8'd0;
                rtn_pkg::D_FAR:  d_reg <= rtn_pkg::FAR_DIST;
                rtn_pkg::D_RAM:  d_reg <= rt_rdata;
                default:         d_reg <= rtn_pkg::FAR_DIST;
            endcase
        end
        if (cmd.cmp)
        begin
            slot_reg <= SW'(slot_reg + 1'b1);
            if (better)
            begin
                best_reg <= d_reg;
                pick_reg <= cand_zone_reg;
                link_reg <= cand_link_reg;
            end
        end
        if (cmd.total_add)
        begin
            total_reg <= total_reg + 24'(link_reg);
        end
        if (cmd.step)
        begin
            cur_reg  <= pick_reg;
            hops_reg <= HW'(hops_reg + 1'b1);
        end
        if (cmd.res_set)
        begin
            res_zone_reg <= res_zone_next;
            res_len_reg  <= res_len_next;
            res_dist_reg <= res_dist_next;
            res_fail_reg <= res_fail_next;
        end
        if (cmd.out_ld)
        begin
            zone_out_reg       <= res_zone_reg;
            length_out_reg     <= res_len_reg;
            route_distance_reg <= res_dist_reg;
            no_reach_reg       <= res_fail_reg;
        end
    end

    always_comb
    begin
        st            = '0;
        st.in_kind    = kind;
        st.kind       = kind_reg;
        st.same       = (cur_reg == to_reg);
        st.cur_oob    = ({1'b0, cur_reg} >= 9'(MAX_ZONES));
        st.nb_end     = (nb_rdata[7:0] == rtn_pkg::NO_ZONE);
        st.nb_is_to   = (nb_rdata[7:0] == to_reg);
        st.addr_oob   = idx[20] || (idx[19:0] >= 20'(RT_DEPTH));
        st.last_slot  = (slot_reg == SW'(NEIGHBOURS - 1));
        st.hops_max   = (hops_reg == HW'(MAX_ZONES));
        st.over_limit = (kind_reg == rtn_pkg::K_LIMIT) && (total_reg > limit_reg);
        st.stuck      = (pick_reg == cur_reg);
        st.clr_last   = (clr_cnt_reg == NB_AW'(NB_DEPTH - 1));
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign zone_out       = zone_out_reg;
    assign length_out     = length_out_reg;
    assign route_distance = route_distance_reg;
    assign no_reach       = no_reach_reg;

endmodule

### rtl/core/route_table_navigator.sv
// Next-hop router over a triangular zone-to-zone hop table plus per-zone neighbour
// lists. Kind 0 and 1 beats load a route word or a neighbour slot and are taken one
// per cycle with no result. Kind 2/3 (next hop, ties to first/last) and kind 6
// (smallest neighbour distance) scan the start zone's neighbour slots, each slot
// costing one neighbour memory read and, unless it holds the target, one triangular
// address multiply and one route memory read. Kind 4 (walk length) and kind 5 (walk
// with limit) repeat that scan once per hop, up to MAX_ZONES hops. A beat is taken
// only while the sequencer is idle; a finished result waits in the output register
// while the next beat is accepted. After reset a clearing pass over all
// MAX_ZONES*NEIGHBOURS slots (768 at default) marks every neighbour slot empty and
// in_ready stays low until it ends. zone_count must be written only while no query
// is in flight, since a scan reads it on every slot; the block does not enforce it.
// Route words that were never loaded read as unknown; unloaded link lengths read as zero.
module route_table_navigator #(
    parameter int MAX_ZONES  = 128,
    parameter int NEIGHBOURS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: zone_count
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  from_zone,
    input  logic [7:0]  to_zone,
    input  logic [23:0] walk_limit,
    input  logic [12:0] route_index,
    input  logic [7:0]  route_value,
    input  logic [2:0]  slot,
    input  logic [7:0]  neighbour_zone,
    input  logic [15:0] link_length,
    // result beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  zone_out,
    output logic [23:0] length_out,
    output logic [7:0]  route_distance,
    output logic        no_reach
);

    rtn_pkg::cmd_t cmd;
    rtn_pkg::sts_t st;

    // sequencer for clearing, scans and walks
    rtn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // tables, scan registers and output register
    rtn_datapath #(
        .MAX_ZONES  (MAX_ZONES),
        .NEIGHBOURS (NEIGHBOURS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .kind           (kind),
        .from_zone      (from_zone),
        .to_zone        (to_zone),
        .walk_limit     (walk_limit),
        .route_index    (route_index),
        .route_value    (route_value),
        .slot           (slot),
        .neighbour_zone (neighbour_zone),
        .link_length    (link_length),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .zone_out       (zone_out),
        .length_out     (length_out),
        .route_distance (route_distance),
        .no_reach       (no_reach)
    );

    // a result never overwrites one still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> st.out_free)
        else $error("result loaded over a pending beat");

    // a walk only advances to a different zone
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !st.stuck)
        else $error("walk stepped without moving");

    // the hop cap is checked before every scan of a walk
    a_step_under_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !st.hops_max)
        else $error("walk stepped past hop cap");

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // table sizes of the default build
    localparam int ZONES      = 128;
    localparam int SLOTS      = 6;
    localparam int ROUTE_SIZE = ZONES * (ZONES - 1) / 2;
    localparam int NB_SIZE    = ZONES * SLOTS;
    // zones that carry neighbour lists and serve as query targets
    localparam int SET_ZONES  = 16;
    // longest quiet stretch: a full hop-capped walk plus stalls
    localparam int QUIET_LIMIT = 40000;
    localparam int SETTLE      = 60;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  from_zone;
        logic [7:0]  to_zone;
        logic [23:0] walk_limit;
        logic [12:0] route_index;
        logic [7:0]  route_value;
        logic [2:0]  slot;
        logic [7:0]  neighbour_zone;
        logic [15:0] link_length;
    } request_t;

    typedef struct {
        logic [7:0]  zone_out;
        logic [23:0] length_out;
        logic [7:0]  route_distance;
        logic        no_reach;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = 3'd0;
    logic [7:0]  from_zone = 8'd0;
    logic [7:0]  to_zone = 8'd0;
    logic [23:0] walk_limit = 24'd0;
    logic [12:0] route_index = 13'd0;
    logic [7:0]  route_value = 8'd0;
    logic [2:0]  slot = 3'd0;
    logic [7:0]  neighbour_zone = 8'd0;
    logic [15:0] link_length = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  zone_out;
    logic [23:0] length_out;
    logic [7:0]  route_distance;
    logic        no_reach;

    route_table_navigator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .from_zone      (from_zone),
        .to_zone        (to_zone),
        .walk_limit     (walk_limit),
        .route_index    (route_index),
        .route_value    (route_value),
        .slot           (slot),
        .neighbour_zone (neighbour_zone),
        .link_length    (link_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .zone_out       (zone_out),
        .length_out     (length_out),
        .route_distance (route_distance),
        .no_reach       (no_reach)
    );

    always #5 clk = ~clk;

    // shadow copy of the block's tables and register
    logic [7:0]  hop_table [ROUTE_SIZE];
    logic [7:0]  nb_zone   [NB_SIZE];
    logic [15:0] nb_link   [NB_SIZE];
    logic [7:0]  zones_used = 8'd128;

    answer_t pending_answers[$];
    int      errors = 0;
    int      answers_seen = 0;
    int      queries_by_kind [8];
    int      quiet_cycles = 0;
    // sender and receiver pacing: when set, no gaps are inserted
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;
    int      rx_hold = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // triangular address of the pair (lo < hi) for a given zone count
    function automatic longint tri_addr(int lo, int hi, int n);
        longint l, h, m;
        l = lo;
        h = hi;
        m = n;
        return (l * (2 * m - l - 3)) / 2 + h - 1;
    endfunction

    function automatic logic [7:0] hop_dist(logic [7:0] a, logic [7:0] b);
        longint addr;
        if (a == b)
            return 8'd0;
        if (a < b)
            addr = tri_addr(int'(a), int'(b), int'(zones_used));
        else
            addr = tri_addr(int'(b), int'(a), int'(zones_used));
        if (addr < 0 || addr >= ROUTE_SIZE)
            return rtn_pkg::FAR_DIST;
        return hop_table[addr];
    endfunction

    // nearest neighbour of a zone toward a target
    task automatic nearest_hop(input logic [7:0] at, input logic [7:0] target,
                               input bit ties_last, output logic [7:0] pick,
                               output logic [7:0] best, output logic [15:0] link);
        logic [7:0] cand, d;
        int i;
        pick = at;
        best = rtn_pkg::FAR_DIST;
        link = 16'd0;
        if (int'(at) < ZONES)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                cand = nb_zone[int'(at) * SLOTS + i];
                if (cand == rtn_pkg::NO_ZONE)
                    break;
                d = hop_dist(cand, target);
                if (d < best || (ties_last && d == best))
                begin
                    best = d;
                    pick = cand;
                    link = nb_link[int'(at) * SLOTS + i];
                end
            end
        end
    endtask

    // greedy walk, optionally stopping once the running length passes the bound
    task automatic greedy_walk(input logic [7:0] start, input logic [7:0] target,
                               input bit bounded, input logic [23:0] bound,
                               output logic [7:0] stop, output logic [31:0] total,
                               output logic stuck);
        logic [7:0]  at, nxt, best;
        logic [15:0] link;
        int hops;
        at = start;
        total = 32'd0;
        stuck = 1'b0;
        hops = 0;
        while (at != target)
        begin
            if (hops >= ZONES)
            begin
                stuck = 1'b1;
                break;
            end
            nearest_hop(at, target, 1'b0, nxt, best, link);
            total = total + 32'(link);
            if (bounded && total > 32'(bound))
                break;
            if (nxt == at)
            begin
                stuck = 1'b1;
                break;
            end
            at = nxt;
            hops++;
        end
        stop = at;
    endtask

    // update the shadow tables and queue the answer for an accepted beat
    task automatic apply_request(input request_t r);
        answer_t     a;
        logic [7:0]  best;
        logic [15:0] link;
        logic [31:0] total;
        a = '{8'd0, 24'd0, 8'd0, 1'b0};
        total = 32'd0;
        case (r.kind)
            rtn_pkg::K_LOAD_ROUTE:
            begin
                if (int'(r.route_index) < ROUTE_SIZE)
                    hop_table[r.route_index] = r.route_value;
                return;
            end
            rtn_pkg::K_LOAD_NB:
            begin
                if (int'(r.from_zone) < ZONES && int'(r.slot) < SLOTS)
                begin
                    nb_zone[int'(r.from_zone) * SLOTS + int'(r.slot)] = r.neighbour_zone;
                    nb_link[int'(r.from_zone) * SLOTS + int'(r.slot)] = r.link_length;
                end
                return;
            end
            rtn_pkg::K_HOP_FIRST, rtn_pkg::K_HOP_LAST:
            begin
                if (r.from_zone == r.to_zone)
                    a.zone_out = r.to_zone;
                else
                    nearest_hop(r.from_zone, r.to_zone, r.kind == rtn_pkg::K_HOP_LAST,
                                a.zone_out, best, link);
            end
            rtn_pkg::K_LENGTH:
            begin
                greedy_walk(r.from_zone, r.to_zone, 1'b0, 24'd0, a.zone_out, total,
                            a.no_reach);
                a.length_out = a.no_reach ? rtn_pkg::FAIL_LENGTH : total[23:0];
            end
            rtn_pkg::K_LIMIT:
            begin
                greedy_walk(r.from_zone, r.to_zone, 1'b1, r.walk_limit, a.zone_out,
                            total, a.no_reach);
                a.length_out = total[23:0];
            end
            rtn_pkg::K_MIN_DIST:
            begin
                if (r.from_zone == r.to_zone)
                    a.route_distance = r.to_zone;
                else
                    nearest_hop(r.from_zone, r.to_zone, 1'b0, a.zone_out,
                                a.route_distance, link);
                a.zone_out = 8'd0;
            end
            default:
                return;
        endcase
        queries_by_kind[r.kind]++;
        pending_answers.push_back(a);
    endtask

    task automatic send_beat(input request_t r);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        kind           <= r.kind;
        from_zone      <= r.from_zone;
        to_zone        <= r.to_zone;
        walk_limit     <= r.walk_limit;
        route_index    <= r.route_index;
        route_value    <= r.route_value;
        slot           <= r.slot;
        neighbour_zone <= r.neighbour_zone;
        link_length    <= r.link_length;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_request(r);
    endtask

    // random filler for every field, so unused bits toggle too
    function automatic request_t noise_request(logic [2:0] k);
        request_t r;
        r.kind           = k;
        r.from_zone      = 8'($urandom_range(0, 255));
        r.to_zone        = 8'($urandom_range(0, 255));
        r.walk_limit     = 24'($urandom_range(0, 24'hFFFFFF));
        r.route_index    = 13'($urandom_range(0, 8191));
        r.route_value    = 8'($urandom_range(0, 255));
        r.slot           = 3'($urandom_range(0, 7));
        r.neighbour_zone = 8'($urandom_range(0, 255));
        r.link_length    = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic load_route(int addr, int value);
        request_t r;
        r = noise_request(rtn_pkg::K_LOAD_ROUTE);
        r.route_index = 13'(addr);
        r.route_value = 8'(value);
        send_beat(r);
    endtask

    task automatic load_slot(int zone, int s, int nb, int len);
        request_t r;
        r = noise_request(rtn_pkg::K_LOAD_NB);
        r.from_zone = 8'(zone);
        r.slot = 3'(s);
        r.neighbour_zone = 8'(nb);
        r.link_length = 16'(len);
        send_beat(r);
    endtask

    task automatic ask(logic [2:0] k, int from, int to, int bound);
        request_t r;
        r = noise_request(k);
        r.from_zone = 8'(from);
        r.to_zone = 8'(to);
        r.walk_limit = 24'(bound);
        send_beat(r);
    endtask

    // drop valid and let every expected beat come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_zone_count(logic [7:0] n);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        zones_used = n;
    endtask

    // route words of every pair among the query zones under the current indexing,
    // so no query reads an unwritten entry; distance is |a-b|
    task automatic fill_routes();
        int a, b;
        longint addr;
        tx_steady = 1'b1;
        for (a = 0; a < SET_ZONES; a++)
            for (b = a + 1; b < SET_ZONES; b++)
            begin
                addr = tri_addr(a, b, int'(zones_used));
                if (addr >= 0 && addr < ROUTE_SIZE)
                    load_route(int'(addr), b - a);
            end
        tx_steady = 1'b0;
    endtask

    // routes plus neighbour lists z-2..z+2 for the query zones
    task automatic test_table_fill();
        int a, i, n, list [$];
        fill_routes();
        tx_steady = 1'b1;
        for (a = 0; a < SET_ZONES; a++)
        begin
            list = {};
            for (n = a - 2; n <= a + 2; n++)
                if (n >= 0 && n < SET_ZONES && n != a)
                    list.push_back(n);
            for (i = 0; i < SLOTS; i++)
                load_slot(a, i, i < list.size() ? list[i] : int'(rtn_pkg::NO_ZONE),
                          $urandom_range(0, 99) < 10 ? $urandom_range(0, 65535)
                                                     : $urandom_range(1, 900));
        end
        tx_steady = 1'b0;
    endtask

    // edges of the fields and the corner cases named for the block
    task automatic test_corners();
        // unused kind and loads that fall outside the tables
        send_beat(noise_request(3'd7));
        load_route(ROUTE_SIZE, 8'hAA);
        load_route(8191, 8'h55);
        load_slot(200, 0, 3, 16'hFFFF);
        load_slot(5, 6, 3, 16'h1234);
        load_slot(5, 7, 3, 16'h4321);
        // start equals target for every query
        ask(rtn_pkg::K_HOP_FIRST, 40, 40, 0);
        ask(rtn_pkg::K_HOP_LAST, 255, 255, 0);
        ask(rtn_pkg::K_LENGTH, 17, 17, 0);
        ask(rtn_pkg::K_LIMIT, 0, 0, 0);
        ask(rtn_pkg::K_MIN_DIST, 99, 99, 0);
        // tie between neighbours 11 and 12 of zone 10 toward zone 15
        load_route(int'(tri_addr(11, 15, ZONES)), 2);
        load_route(int'(tri_addr(12, 15, ZONES)), 2);
        ask(rtn_pkg::K_HOP_FIRST, 10, 15, 0);
        ask(rtn_pkg::K_HOP_LAST, 10, 15, 0);
        ask(rtn_pkg::K_MIN_DIST, 10, 15, 0);
        // zone with no row, or with an empty list, stalls at once
        ask(rtn_pkg::K_LENGTH, 200, 5, 0);
        ask(rtn_pkg::K_LIMIT, 255, 5, 24'hFFFFFF);
        ask(rtn_pkg::K_HOP_FIRST, 100, 5, 0);
        // limit walk over its bound at the first step, and one that never hits it
        ask(rtn_pkg::K_LIMIT, 3, 14, 0);
        ask(rtn_pkg::K_LIMIT, 3, 14, 24'hFFFFFF);
        ask(rtn_pkg::K_LENGTH, 0, 15, 0);
        // stall: neighbours of zone 5 all at far distance from zone 9
        load_route(int'(tri_addr(3, 9, ZONES)), 255);
        load_route(int'(tri_addr(4, 9, ZONES)), 255);
        load_route(int'(tri_addr(6, 9, ZONES)), 255);
        load_route(int'(tri_addr(7, 9, ZONES)), 255);
        ask(rtn_pkg::K_LENGTH, 5, 9, 0);
        // two zones pointing at each other until the hop cap runs out
        load_slot(14, 0, 15, 7);
        load_slot(14, 1, int'(rtn_pkg::NO_ZONE), 0);
        load_slot(15, 0, 14, 9);
        load_slot(15, 1, int'(rtn_pkg::NO_ZONE), 0);
        ask(rtn_pkg::K_LENGTH, 14, 0, 0);
        ask(rtn_pkg::K_LIMIT, 15, 0, 24'hFFFFFF);
    endtask

    // queries target the filled zones; loads and noise keep the tables moving
    task automatic test_random_mix(int count, int walk_pct);
        request_t r;
        int i, roll;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                r = noise_request(rtn_pkg::K_LOAD_ROUTE);
                if ($urandom_range(0, 9) != 0)
                    r.route_index = 13'($urandom_range(0, ROUTE_SIZE - 1));
            end
            else if (roll < 20)
            begin
                r = noise_request(rtn_pkg::K_LOAD_NB);
                if ($urandom_range(0, 9) != 0)
                begin
                    r.from_zone = 8'($urandom_range(0, SET_ZONES + 3));
                    r.slot = 3'($urandom_range(0, SLOTS - 1));
                    r.neighbour_zone = ($urandom_range(0, 3) == 0) ? rtn_pkg::NO_ZONE
                                       : 8'($urandom_range(0, SET_ZONES - 1));
                end
                else if ($urandom_range(0, 1))
                    r.from_zone = 8'($urandom_range(ZONES, 255));
                else
                    r.slot = 3'($urandom_range(SLOTS, 7));
            end
            else if (roll < 23)
                r = noise_request(3'd7);
            else
            begin
                if ($urandom_range(0, 99) < walk_pct)
                    r = noise_request($urandom_range(0, 1) ? rtn_pkg::K_LENGTH
                                                           : rtn_pkg::K_LIMIT);
                else
                    case ($urandom_range(0, 2))
                        0: r = noise_request(rtn_pkg::K_HOP_FIRST);
                        1: r = noise_request(rtn_pkg::K_HOP_LAST);
                        default: r = noise_request(rtn_pkg::K_MIN_DIST);
                    endcase
                if ($urandom_range(0, 9) != 0)
                    r.from_zone = 8'($urandom_range(0, SET_ZONES - 1));
                if ($urandom_range(0, 19) == 0)
                    r.to_zone = r.from_zone;
                else
                    r.to_zone = 8'($urandom_range(0, SET_ZONES - 1));
                if ($urandom_range(0, 1))
                    r.walk_limit = 24'($urandom_range(0, 12000));
            end
            send_beat(r);
        end
        tx_steady = 1'b0;
    endtask

    // new zone count, matching route words, then random traffic
    task automatic test_zone_count(logic [7:0] n, int count, int walk_pct);
        set_zone_count(n);
        fill_routes();
        test_random_mix(count, walk_pct);
    endtask

    // result side: random stalls, with stretches of steady acceptance
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 25)
                rx_hold <= pick_gap();
        end
    end

    always @(posedge clk)
        if ($urandom_range(0, 499) == 0)
            rx_steady <= ~rx_steady;

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
                report("unexpected result beat", 1, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (zone_out !== want.zone_out)
                    report("zone_out", longint'(zone_out), longint'(want.zone_out));
                if (length_out !== want.length_out)
                    report("length_out", longint'(length_out), longint'(want.length_out));
                if (route_distance !== want.route_distance)
                    report("route_distance", longint'(route_distance),
                           longint'(want.route_distance));
                if (no_reach !== want.no_reach)
                    report("no_reach", longint'(no_reach), longint'(want.no_reach));
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     pending_answers.size());
            $display("route_table_navigator test failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < ROUTE_SIZE; i++)
            hop_table[i] = 8'd0;
        for (i = 0; i < NB_SIZE; i++)
        begin
            nb_zone[i] = rtn_pkg::NO_ZONE;
            nb_link[i] = 16'd0;
        end
        for (i = 0; i < 8; i++)
            queries_by_kind[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_zone_count(8'd128);
        test_table_fill();
        test_corners();
        // hold the sender until all answers are back
        drain();
        test_random_mix(250, 30);
        test_zone_count(8'd1, 120, 10);
        test_zone_count(8'd127, 120, 10);
        test_zone_count(8'd64, 120, 10);
        test_zone_count(8'd128, 200, 30);
        drain();

        $display("checked %0d results: hop %0d/%0d, length %0d, limit %0d, min %0d",
                 answers_seen, queries_by_kind[rtn_pkg::K_HOP_FIRST],
                 queries_by_kind[rtn_pkg::K_HOP_LAST], queries_by_kind[rtn_pkg::K_LENGTH],
                 queries_by_kind[rtn_pkg::K_LIMIT], queries_by_kind[rtn_pkg::K_MIN_DIST]);
        $display("zone counts 128, 1, 127 and 64 used, %0d mismatches", errors);
        if (errors == 0 && pending_answers.size() == 0)
            $display("route_table_navigator test passed");
        else
            $display("route_table_navigator test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/rtn_pkg.sv
rtl/core/rtn_ram.sv
rtl/core/rtn_ctrl.sv
rtl/core/rtn_datapath.sv
rtl/core/route_table_navigator.sv
sim/tb.sv
